// File: hw/rtl/c3zp_pkg.sv
package c3zp_pkg;

   localparam int unsigned PIX_W   = 8;
   localparam int unsigned VAL_W   = 28;
   localparam int unsigned POS_W   = 6;
   localparam int unsigned SIZE_W  = 7;
   localparam int unsigned KROW_W  = 48;
   localparam int unsigned COEF_W  = 16;
   localparam int unsigned CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_K_TOP   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_K_MID   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_K_BOT   = 3'd4;

   // one unit of work for the back end: a 3x3 window with padding already applied
   typedef struct packed {
      logic [8:0][PIX_W-1:0] win;
      logic [POS_W-1:0]      row;
      logic [POS_W-1:0]      col;
      logic                  fin;
   } job_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] value;
      logic [POS_W-1:0]        row;
      logic [POS_W-1:0]        col;
      logic                    fin;
   } res_type;

endpackage

// File: hw/rtl/conv3x3_zero_pad_stream.sv
// Streaming 3x3 convolution with zero padding.
// Path: a pixel that completes a result passes the line-store read, window update, queue
// and product stage, each registered; the sum is then registered.
// Throughput: one pixel per cycle when it yields at most one result and nothing stalls; a pixel
// yielding more holds input while the window stage issues its jobs, one per cycle unless stalled.
// Reset clears position, window, queue and pipeline; sizes go to 1, kernel to zero.
module conv3x3_zero_pad_stream #(
   parameter int unsigned MAX_WIDTH  = 64,
   parameter int unsigned MAX_HEIGHT = 64
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   output logic full,
   input  logic [c3zp_pkg::PIX_W-1:0] req_pixel,
   output logic empty,
   input  logic pop,
   output logic signed [c3zp_pkg::VAL_W-1:0] rsp_value,
   output logic [c3zp_pkg::POS_W-1:0] rsp_out_row,
   output logic [c3zp_pkg::POS_W-1:0] rsp_out_col,
   output logic rsp_final_res,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [c3zp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [c3zp_pkg::KROW_W-1:0] csr_data
);
   import c3zp_pkg::*;

   logic [SIZE_W-1:0] width_ff, height_ff;
   logic [2:0][KROW_W-1:0] krow_ff;
   logic f_valid, f_ready, q_valid, q_ready, b_valid, busy;
   job_type f_job, q_job;
   res_type b_res;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= SIZE_W'(1);
         height_ff <= SIZE_W'(1);
         krow_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_WIDTH:  width_ff <= csr_data[SIZE_W-1:0];
            CSR_HEIGHT: height_ff <= csr_data[SIZE_W-1:0];
            CSR_K_TOP:  krow_ff[0] <= csr_data;
            CSR_K_MID:  krow_ff[1] <= csr_data;
            CSR_K_BOT:  krow_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   c3zp_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
      .clock(clock), .reset(reset), .cfg_width(width_ff), .cfg_height(height_ff),
      .push(push), .full(full), .pixel(req_pixel),
      .job_valid(f_valid), .job(f_job), .job_ready(f_ready), .busy(busy));

   c3zp_queue #(.WIDTH($bits(job_type)), .DEPTH(4)) u_queue (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_ready(f_ready), .in_data(f_job),
      .out_valid(q_valid), .out_ready(q_ready), .out_data(q_job));

   c3zp_back u_back (
      .clock(clock), .reset(reset), .krow(krow_ff),
      .in_valid(q_valid), .in_ready(q_ready), .in_job(q_job),
      .out_valid(b_valid), .out_ready(pop), .out_res(b_res));

   assign empty = !b_valid;
   assign rsp_value = b_res.value;
   assign rsp_out_row = b_res.row;
   assign rsp_out_col = b_res.col;
   assign rsp_final_res = b_res.fin;

   a_full_needs_busy: assert property (@(posedge clock) disable iff (reset)
      full |-> busy) else $error("full while front idle");
   a_res_holds: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_value)))
      else $error("result changed while waiting");
   a_no_job_idle: assert property (@(posedge clock) disable iff (reset)
      f_valid |-> busy) else $error("job without work");
endmodule

// File: hw/rtl/c3zp_ram.sv
module c3zp_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// File: hw/rtl/c3zp_front.sv
// Accepts pixels, keeps line stores and window, emits up to four window jobs per pixel.
module c3zp_front #(
   parameter int unsigned MAX_WIDTH  = 64,
   parameter int unsigned MAX_HEIGHT = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [c3zp_pkg::SIZE_W-1:0] cfg_width,
   input  logic [c3zp_pkg::SIZE_W-1:0] cfg_height,
   input  logic                    push,
   output logic                    full,
   input  logic [c3zp_pkg::PIX_W-1:0] pixel,
   output logic                    job_valid,
   output c3zp_pkg::job_type       job,
   input  logic                    job_ready,
   output logic                    busy
);
   import c3zp_pkg::*;

   localparam int unsigned AW = $clog2(MAX_WIDTH);
   localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
   localparam int unsigned RW = $clog2(MAX_HEIGHT + 1);

   // stage 1: line store read in flight; stage 2: window update, one job per cycle if ready
   logic          s1_ff, s1_in;
   logic [PIX_W-1:0] s1_px_ff;
   logic [CW-1:0] s1_c_ff;
   logic [RW-1:0] s1_r_ff;
   logic          s1_lc_ff, s1_lr_ff;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;

   logic [8:0][PIX_W-1:0] win_ff, win_in;
   logic          s2_ff, s2_in;
   logic [3:0]    pend_ff, pend_in;
   logic [CW-1:0] s2_c_ff;
   logic [RW-1:0] s2_r_ff;

   logic [PIX_W-1:0] up1, up2;
   logic          s1_new_ff;
   logic          fwd_ff;
   logic [PIX_W-1:0] up1_hold_ff, up2_hold_ff, fwd_px_ff;
   logic [PIX_W-1:0] up2_cur, up1_s, up2_s;

   logic [CW-1:0] w_sz;
   logic [RW-1:0] h_sz;
   logic [CW-1:0] c_eff, c_nx;
   logic [RW-1:0] r_eff, r_nx;
   logic          acc;

   always_comb begin
      if (cfg_width == '0) w_sz = CW'(1);
      else if (32'(cfg_width) > MAX_WIDTH) w_sz = CW'(MAX_WIDTH);
      else w_sz = CW'(cfg_width);
      if (cfg_height == '0) h_sz = RW'(1);
      else if (32'(cfg_height) > MAX_HEIGHT) h_sz = RW'(MAX_HEIGHT);
      else h_sz = RW'(cfg_height);
   end

   always_comb begin
      c_eff = col_ff;
      r_eff = row_ff;
      if (c_eff >= w_sz) begin
         c_eff = '0;
         r_eff = r_eff + RW'(1);
      end
      if (r_eff >= h_sz) r_eff = '0;
      c_nx = c_eff + CW'(1);
      r_nx = r_eff;
      if (c_nx >= w_sz) begin
         c_nx = '0;
         r_nx = r_eff + RW'(1);
         if (r_nx >= h_sz) r_nx = '0;
      end
   end

   // stage 2 is free when it is empty or its pending jobs drain this cycle
   logic s2_free;
   logic [3:0] pend_left;
   logic [1:0] pick;
   logic s2_load;

   always_comb begin
      pick = 2'd0;
      for (int k = 3; k >= 0; k--) if (pend_ff[k]) pick = 2'(k);
      pend_left = pend_ff;
      if (job_valid && job_ready) pend_left[pick] = 1'b0;
   end
   assign s2_free = !s2_ff || (pend_left == '0);
   assign s2_load = s1_ff && s2_free;
   assign full = s1_ff && !s2_free;
   assign acc  = push && !full;

   c3zp_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line1 (
      .clock(clock), .wr_en(acc), .wr_addr(c_eff[AW-1:0]), .wr_data(pixel),
      .rd_addr(c_eff[AW-1:0]), .rd_data(up1));
   logic [PIX_W-1:0] l1_old;
   c3zp_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line1b (
      .clock(clock), .wr_en(acc), .wr_addr(c_eff[AW-1:0]), .wr_data(pixel),
      .rd_addr(c_eff[AW-1:0]), .rd_data(l1_old));
   // second store takes the old first-store entry in the cycle after the pixel is accepted
   c3zp_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line2 (
      .clock(clock), .wr_en(s1_new_ff), .wr_addr(s1_c_ff[AW-1:0]),
      .wr_data(l1_old), .rd_addr(c_eff[AW-1:0]), .rd_data(up2));

   // read data is fresh only in the first stage-1 cycle; held while stage 1 stalls.
   // at width 1 the late second-store write hits the address read by the next item
   assign up2_cur = fwd_ff ? fwd_px_ff : up2;
   assign up1_s = s1_new_ff ? up1 : up1_hold_ff;
   assign up2_s = s1_new_ff ? up2_cur : up2_hold_ff;

   assign s1_in = acc || (s1_ff && !s2_free);
   assign col_in = acc ? c_nx : col_ff;
   assign row_in = acc ? r_nx : row_ff;

   always_comb begin
      win_in = win_ff;
      pend_in = pend_left;
      s2_in = s2_ff && (pend_left != '0);
      if (s2_load) begin
         if (s1_c_ff == '0) win_in = '0;
         for (int i = 0; i < 3; i++) begin
            win_in[i*3+0] = (s1_c_ff == '0) ? '0 : win_ff[i*3+1];
            win_in[i*3+1] = (s1_c_ff == '0) ? '0 : win_ff[i*3+2];
         end
         win_in[2] = (s1_r_ff >= RW'(2)) ? up2_s : '0;
         win_in[5] = (s1_r_ff >= RW'(1)) ? up1_s : '0;
         win_in[8] = s1_px_ff;
         pend_in[0] = (s1_r_ff >= RW'(1)) && (s1_c_ff >= CW'(1));
         pend_in[1] = (s1_r_ff >= RW'(1)) && s1_lc_ff;
         pend_in[2] = s1_lr_ff && (s1_c_ff >= CW'(1));
         pend_in[3] = s1_lr_ff && s1_lc_ff;
         s2_in = pend_in != '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= 1'b0;
         s2_ff <= 1'b0;
         pend_ff <= '0;
         col_ff <= '0;
         row_ff <= '0;
         win_ff <= '0;
         s1_new_ff <= 1'b0;
         fwd_ff <= 1'b0;
      end else begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         pend_ff <= pend_in;
         col_ff <= col_in;
         row_ff <= row_in;
         win_ff <= win_in;
         s1_new_ff <= acc;
         fwd_ff <= acc && s1_new_ff && (c_eff == s1_c_ff);
      end
      if (s1_new_ff) begin
         up1_hold_ff <= up1;
         up2_hold_ff <= up2_cur;
         fwd_px_ff   <= l1_old;
      end
      if (acc) begin
         s1_px_ff <= pixel;
         s1_c_ff  <= c_eff;
         s1_r_ff  <= r_eff;
         s1_lc_ff <= (c_eff == w_sz - CW'(1));
         s1_lr_ff <= (r_eff == h_sz - RW'(1));
      end
      if (s2_load) begin
         s2_c_ff <= s1_c_ff;
         s2_r_ff <= s1_r_ff;
      end
   end

   // padded window for centre (ci,cj): shift view so centre lands at index 4
   always_comb begin
      logic [1:0] ci, cj;
      logic [POS_W-1:0] r_o, c_o;
      ci = pick[1] ? 2'd2 : 2'd1;
      cj = pick[0] ? 2'd2 : 2'd1;
      r_o = pick[1] ? POS_W'(s2_r_ff) : POS_W'(s2_r_ff - RW'(1));
      c_o = pick[0] ? POS_W'(s2_c_ff) : POS_W'(s2_c_ff - CW'(1));
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) begin
            if (32'(ci) + i - 1 <= 2 && 32'(cj) + j - 1 <= 2)
               job.win[i*3+j] = win_ff[(32'(ci) + i - 1) * 3 + 32'(cj) + j - 1];
            else
               job.win[i*3+j] = '0;
         end
      job.row = r_o;
      job.col = c_o;
      job.fin = (pick == 2'd3);
   end
   assign job_valid = s2_ff && (pend_ff != '0);
   assign busy = s1_ff || s2_ff;
endmodule

// File: hw/rtl/c3zp_queue.sv
// Short job queue between front and back.
module c3zp_queue #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);
   localparam int unsigned AW = $clog2(DEPTH);
   logic [WIDTH-1:0] buf_ff [DEPTH];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [AW:0]   cnt_ff;
   logic push_q, pop_q;

   assign in_ready  = cnt_ff != (AW+1)'(DEPTH);
   assign out_valid = cnt_ff != '0;
   assign out_data  = buf_ff[rp_ff];
   assign push_q = in_valid && in_ready;
   assign pop_q  = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push_q) wp_ff <= (wp_ff == AW'(DEPTH-1)) ? '0 : wp_ff + AW'(1);
         if (pop_q)  rp_ff <= (rp_ff == AW'(DEPTH-1)) ? '0 : rp_ff + AW'(1);
         cnt_ff <= cnt_ff + (AW+1)'(push_q) - (AW+1)'(pop_q);
      end
      if (push_q) buf_ff[wp_ff] <= in_data;
   end
endmodule

// File: hw/rtl/c3zp_back.sv
// Multiply-accumulate of one window: nine products in one stage, their sum in the next.
module c3zp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [2:0][c3zp_pkg::KROW_W-1:0] krow,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  c3zp_pkg::job_type    in_job,
   output logic                 out_valid,
   input  logic                 out_ready,
   output c3zp_pkg::res_type    out_res
);
   import c3zp_pkg::*;

   // stage a: nine products registered; stage b: sum registered
   logic a_ff, b_ff;
   logic signed [8:0][COEF_W+PIX_W:0] prod_ff;
   logic [POS_W-1:0] a_row_ff, a_col_ff;
   logic a_fin_ff;
   res_type b_ff_res;
   logic adv_b, adv_a;
   logic signed [VAL_W-1:0] sum;

   assign adv_b = !b_ff || out_ready;
   assign adv_a = !a_ff || adv_b;
   assign in_ready = adv_a;

   // elements of a packed array are unsigned, so sign is restored before extension
   always_comb begin
      sum = '0;
      for (int i = 0; i < 9; i++) sum = sum + VAL_W'($signed(prod_ff[i]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff <= 1'b0;
         b_ff <= 1'b0;
      end else begin
         if (adv_a) a_ff <= in_valid;
         if (adv_b) b_ff <= a_ff;
      end
      if (adv_a && in_valid) begin
         // window index 3*i+j pairs with K[2-i][2-j]
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
               prod_ff[i*3+j] <= $signed(krow[2-i][(2-j)*COEF_W +: COEF_W])
                  * $signed({1'b0, in_job.win[i*3+j]});
         a_row_ff <= in_job.row;
         a_col_ff <= in_job.col;
         a_fin_ff <= in_job.fin;
      end
      if (adv_b && a_ff) begin
         b_ff_res.value <= sum;
         b_ff_res.row <= a_row_ff;
         b_ff_res.col <= a_col_ff;
         b_ff_res.fin <= a_fin_ff;
      end
   end
   assign out_valid = b_ff;
   assign out_res = b_ff_res;
endmodule
